/* rtl/bmpd_pkg.sv */
// Shared types and constants for the 24-bit BMP stream decoder.
// Used by bmpd_hdr, bmpd_out_reg and bmp24_stream_decoder; depends on nothing.
`timescale 1ns / 1ps

package bmpd_pkg;

  localparam int HDR_BYTES  = 54;
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int DIM_W      = 13;
  localparam int COORD_W    = 12;
  localparam int TDATA_W    = 80;

  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [31:0] INFO_SIZE     = 32'd40;
  localparam logic [15:0] PIXEL_BITS    = 16'd24;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ERR_NONE         = 4'd0,
    ERR_HEADER_SHORT = 4'd1,
    ERR_SIGNATURE    = 4'd2,
    ERR_INFO_SIZE    = 4'd3,
    ERR_PLANES       = 4'd4,
    ERR_DEPTH        = 4'd5,
    ERR_COMPRESSED   = 4'd6,
    ERR_DIMS         = 4'd7,
    ERR_OFFSET       = 4'd8,
    ERR_PIXELS_SHORT = 4'd9,
    ERR_PAD_SHORT    = 4'd10
  } err_e;

  typedef struct packed {
    err_e               err;
    logic [31:0]        offset;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic               bottom_up;
  } hdr_info_t;

  typedef struct packed {
    kind_e              kind;
    err_e               err;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] line;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               last;
  } res_t;

endpackage

/* rtl/bmpd_hdr.sv */
// Header field capture and validation for the BMP stream decoder.
// Collects the checked header fields byte by byte and reports the first failing check.
// Depends on bmpd_pkg.
`timescale 1ns / 1ps

module bmpd_hdr (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [5:0]          pos_i,
  input  logic [7:0]          byte_i,
  output bmpd_pkg::hdr_info_t info_o
);
  import bmpd_pkg::*;

  logic [15:0] sig_q;
  logic [31:0] offset_q;
  logic [31:0] info_size_q;
  logic [31:0] width_q;
  logic [31:0] height_q;
  logic [15:0] planes_q;
  logic [15:0] bpp_q;
  logic [31:0] comp_q;
  logic [1:0]  lane;
  logic [31:0] height_abs;

  assign lane = pos_i[1:0] + 2'd2;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      case (pos_i) inside
        [6'd0:6'd1]:   sig_q[{pos_i[0], 3'b000} +: 8] <= byte_i;
        [6'd10:6'd13]: offset_q[{lane, 3'b000} +: 8] <= byte_i;
        [6'd14:6'd17]: info_size_q[{lane, 3'b000} +: 8] <= byte_i;
        [6'd18:6'd21]: width_q[{lane, 3'b000} +: 8] <= byte_i;
        [6'd22:6'd25]: height_q[{lane, 3'b000} +: 8] <= byte_i;
        [6'd26:6'd27]: planes_q[{pos_i[0], 3'b000} +: 8] <= byte_i;
        [6'd28:6'd29]: bpp_q[{pos_i[0], 3'b000} +: 8] <= byte_i;
        [6'd30:6'd33]: comp_q[{lane, 3'b000} +: 8] <= byte_i;
        default: ;
      endcase
    end
  end

  assign height_abs = height_q[31] ? (32'd0 - height_q) : height_q;

  always_comb begin
    info_o.offset    = offset_q;
    info_o.width     = width_q[DIM_W-1:0];
    info_o.height    = height_abs[DIM_W-1:0];
    info_o.bottom_up = ~height_q[31];
    if (sig_q != BMP_SIGNATURE) begin
      info_o.err = ERR_SIGNATURE;
    end else if (info_size_q != INFO_SIZE) begin
      info_o.err = ERR_INFO_SIZE;
    end else if (planes_q != 16'd1) begin
      info_o.err = ERR_PLANES;
    end else if (bpp_q != PIXEL_BITS) begin
      info_o.err = ERR_DEPTH;
    end else if (comp_q != 32'd0) begin
      info_o.err = ERR_COMPRESSED;
    end else if (width_q == 32'd0 || width_q[31] || width_q > 32'(MAX_WIDTH)) begin
      info_o.err = ERR_DIMS;
    end else if (height_q == 32'd0 || height_abs > 32'(MAX_HEIGHT)) begin
      info_o.err = ERR_DIMS;
    end else if (offset_q < 32'(HDR_BYTES)) begin
      info_o.err = ERR_OFFSET;
    end else begin
      info_o.err = ERR_NONE;
    end
  end

endmodule

/* rtl/bmpd_out_reg.sv */
// Result register of the BMP stream decoder, driving the output stream channel.
// Holds one result until the receiver takes it. Depends on bmpd_pkg.
`timescale 1ns / 1ps

module bmpd_out_reg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  bmpd_pkg::res_t               res_i,
  output logic                         free_o,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [bmpd_pkg::TDATA_W-1:0] m_axis_tdata_o,
  output logic [1:0]                   m_axis_tuser_o,
  output logic                         m_axis_tlast_o
);
  import bmpd_pkg::*;

  logic vld_q;
  res_t res_q;

  assign free_o = ~vld_q | m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load_i) begin
      vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tuser_o  = res_q.kind;
  assign m_axis_tlast_o  = res_q.last;
  assign m_axis_tdata_o  = {2'b00, res_q.blue, res_q.green, res_q.red, res_q.line,
                            res_q.column, res_q.height, res_q.width, res_q.err};

endmodule

/* rtl/bmp24_stream_decoder.sv */
// Top level of the 24-bit uncompressed BMP stream decoder.
// Input register, decode state machine and pixel counters; uses bmpd_hdr,
// bmpd_out_reg and bmpd_pkg.
//
// The file enters one byte per transfer on the s_axis channel, with tlast on the
// final byte of the file. Each result leaves on the m_axis channel: tuser gives
// the kind (header accepted, pixel or error) and tlast marks the final pixel of
// the image. The first failing header check or a truncated file gives one error
// result, and later bytes are dropped until the end of the file, which rearms
// the decoder for the next file.
// A result is loaded into the result register from the input register, which
// holds the byte that causes it, so the byte passes the input register and then
// the result register on its way out. The decoder takes one byte in every cycle
// while the receiver does not stall; each byte needs only counter and field updates.
// Reset empties both registers and returns to header collection.
// When the receiver stalls, the result register holds its result, the input
// register holds one more byte, and s_axis_tready then falls until the result
// is taken.
`timescale 1ns / 1ps

module bmp24_stream_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // Fields from bit 0: data_byte[7:0].
  input  logic [7:0]                   s_axis_tdata_i,
  input  logic                         s_axis_tlast_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // Fields from bit 0: error_code[3:0], image_width[16:4], image_height[29:17],
  // column[41:30], line[53:42], red[61:54], green[69:62], blue[77:70], zero[79:78].
  output logic [bmpd_pkg::TDATA_W-1:0] m_axis_tdata_o,
  // Fields from bit 0: kind[1:0].
  output logic [1:0]                   m_axis_tuser_o,
  output logic                         m_axis_tlast_o
);
  import bmpd_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_SKIP   = 3'd1,
    PH_PIXEL  = 3'd2,
    PH_PAD    = 3'd3,
    PH_IDLE   = 3'd4
  } phase_e;

  localparam logic [31:0] HDR_LAST = 32'(HDR_BYTES - 1);

  logic               in_vld_q;
  logic [7:0]         in_byte_q;
  logic               in_eof_q;
  logic               out_free;
  logic               fire;

  phase_e             phase_q, phase_d;
  logic [31:0]        cnt_q, cnt_d;
  logic [31:0]        off_q, off_d;
  logic               bottom_up_q, bottom_up_d;
  logic [DIM_W-1:0]   width_q, width_d;
  logic [DIM_W-1:0]   height_q, height_d;
  logic [COORD_W-1:0] col_q, col_d;
  logic [DIM_W-1:0]   row_q, row_d;
  logic [1:0]         comp_q, comp_d;
  logic [7:0]         blue_q, blue_d;
  logic [7:0]         green_q, green_d;
  logic [1:0]         pad_q, pad_d;

  logic               hdr_we;
  hdr_info_t          hdr_info;
  res_t               res;
  logic               res_vld;
  logic [DIM_W-1:0]   col_inc;
  logic [DIM_W-1:0]   row_inc;
  logic [DIM_W-1:0]   y_pos;
  logic [1:0]         pad_dec;
  phase_e             row_end_phase;

  assign fire            = in_vld_q & out_free;
  assign s_axis_tready_o = ~in_vld_q | out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_eof_q  <= s_axis_tlast_i;
    end
  end

  bmpd_hdr u_hdr (
    .clk_i   (clk_i),
    .wr_en_i (hdr_we),
    .pos_i   (cnt_q[5:0]),
    .byte_i  (in_byte_q),
    .info_o  (hdr_info)
  );

  assign col_inc       = {1'b0, col_q} + 13'd1;
  assign row_inc       = row_q + 13'd1;
  assign y_pos         = bottom_up_q ? (height_q - 13'd1 - row_q) : row_q;
  assign pad_dec       = pad_q - 2'd1;
  assign row_end_phase = (row_inc >= height_q) ? PH_IDLE : PH_PIXEL;

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    off_d       = off_q;
    bottom_up_d = bottom_up_q;
    width_d     = width_q;
    height_d    = height_q;
    col_d       = col_q;
    row_d       = row_q;
    comp_d      = comp_q;
    blue_d      = blue_q;
    green_d     = green_q;
    pad_d       = pad_q;
    hdr_we      = 1'b0;
    res         = '0;
    res_vld     = 1'b0;
    if (fire) begin
      if (cnt_q != 32'hFFFF_FFFF) begin
        cnt_d = cnt_q + 32'd1;
      end
      unique case (phase_q)
        PH_HEADER: begin
          hdr_we = 1'b1;
          if (cnt_q == HDR_LAST) begin
            res_vld = 1'b1;
            if (hdr_info.err != ERR_NONE) begin
              res.kind = KIND_ERROR;
              res.err  = hdr_info.err;
              phase_d  = PH_IDLE;
            end else begin
              res.kind    = KIND_HEADER;
              res.width   = hdr_info.width;
              res.height  = hdr_info.height;
              off_d       = hdr_info.offset;
              bottom_up_d = hdr_info.bottom_up;
              width_d     = hdr_info.width;
              height_d    = hdr_info.height;
              col_d       = '0;
              row_d       = '0;
              comp_d      = 2'd0;
              phase_d     = (hdr_info.offset <= 32'(HDR_BYTES)) ? PH_PIXEL : PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          if (({1'b0, cnt_q} + 33'd1) >= {1'b0, off_q}) begin
            phase_d = PH_PIXEL;
          end
        end
        PH_PIXEL: begin
          case (comp_q)
            2'd0: begin
              blue_d = in_byte_q;
              comp_d = 2'd1;
            end
            2'd1: begin
              green_d = in_byte_q;
              comp_d  = 2'd2;
            end
            default: begin
              comp_d     = 2'd0;
              res_vld    = 1'b1;
              res.kind   = KIND_PIXEL;
              res.column = col_q;
              res.line   = y_pos[COORD_W-1:0];
              res.red    = in_byte_q;
              res.green  = green_q;
              res.blue   = blue_q;
              res.last   = (col_inc == width_q) && (row_inc == height_q);
              if (col_inc >= width_q) begin
                col_d = '0;
                pad_d = width_q[1:0];
                if (width_q[1:0] != 2'd0) begin
                  phase_d = PH_PAD;
                end else begin
                  row_d   = row_inc;
                  phase_d = row_end_phase;
                end
              end else begin
                col_d = col_inc[COORD_W-1:0];
              end
            end
          endcase
        end
        PH_PAD: begin
          pad_d = pad_dec;
          if (pad_dec == 2'd0) begin
            row_d   = row_inc;
            phase_d = row_end_phase;
          end
        end
        PH_IDLE: ;
        default: ;
      endcase
      if (in_eof_q) begin
        if (phase_d != PH_IDLE) begin
          res      = '0;
          res_vld  = 1'b1;
          res.kind = KIND_ERROR;
          if (phase_d == PH_HEADER) begin
            res.err = ERR_HEADER_SHORT;
          end else if (phase_d == PH_PAD) begin
            res.err = ERR_PAD_SHORT;
          end else begin
            res.err = ERR_PIXELS_SHORT;
          end
        end
        phase_d = PH_HEADER;
        cnt_d   = '0;
        comp_d  = 2'd0;
        col_d   = '0;
        row_d   = '0;
        pad_d   = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      cnt_q       <= '0;
      off_q       <= '0;
      bottom_up_q <= 1'b0;
      width_q     <= '0;
      height_q    <= '0;
      col_q       <= '0;
      row_q       <= '0;
      comp_q      <= 2'd0;
      blue_q      <= '0;
      green_q     <= '0;
      pad_q       <= 2'd0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      off_q       <= off_d;
      bottom_up_q <= bottom_up_d;
      width_q     <= width_d;
      height_q    <= height_d;
      col_q       <= col_d;
      row_q       <= row_d;
      comp_q      <= comp_d;
      blue_q      <= blue_d;
      green_q     <= green_d;
      pad_q       <= pad_d;
    end
  end

  bmpd_out_reg u_out_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (fire & res_vld),
    .res_i           (res),
    .free_o          (out_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  a_header_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HEADER |-> cnt_q < 32'(HDR_BYTES))
    else $error("Header collection ran past the header length.");

  a_component_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    comp_q != 2'd3)
    else $error("Component index left the BGR triple.");

  a_pixel_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PIXEL |-> ({1'b0, col_q} < width_q) && (row_q < height_q))
    else $error("Pixel counters outside the image.");

  a_eof_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_eof_q |=> phase_q == PH_HEADER && cnt_q == 32'd0)
    else $error("End of file did not rearm header collection.");

  a_last_is_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o == KIND_PIXEL)
    else $error("Final-pixel mark on a result that is not a pixel.");

endmodule
